[src/ptsc_pkg.sv]
// ----------------------------------------------------------------------------
// ptsc_pkg: shared types, constants and the table of the pan/tilt slew controller
// Holds the command codes, register indexes, the beat formats between the
// front and back parts, and the unit-vector coefficient table.
// ----------------------------------------------------------------------------
package ptsc_pkg;

  // Fixed field widths
  localparam int ANG_W  = 16;
  localparam int STEP_W = 12;
  localparam int FUNC_W = 3;
  localparam int KEY_W  = 8;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 16;
  localparam int DELTA_W = STEP_W + 1;

  // Default number of fraction bits of an angle
  localparam int FRAC_BITS_DEF = 8;

  // Unit-vector coefficients: COEF_FRAC fraction bits, value up to 1.0
  localparam int COEF_FRAC = 34;
  localparam int COEF_W    = COEF_FRAC + 1;
  localparam int WIDE_W    = 80;

  // Queue depth between front and back, and of the result queue
  localparam int QUEUE_DEPTH = 2;

  // Command codes
  typedef enum logic [FUNC_W-1:0] {
    CMD_NONE    = 3'd0,
    CMD_HOME    = 3'd1,
    CMD_SAVE    = 3'd2,
    CMD_RESTORE = 3'd3,
    CMD_SET     = 3'd4
  } cmd_t;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_PAN_MIN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_PAN_MAX   = 3'd1;
  localparam logic [IDX_W-1:0] REG_TILT_MIN  = 3'd2;
  localparam logic [IDX_W-1:0] REG_TILT_MAX  = 3'd3;
  localparam logic [IDX_W-1:0] REG_SLEW_STEP = 3'd4;
  localparam logic [IDX_W-1:0] REG_MOVE_STEP = 3'd5;
  localparam logic [IDX_W-1:0] REG_HOME_PAN  = 3'd6;
  localparam logic [IDX_W-1:0] REG_HOME_TILT = 3'd7;

  // Configuration register set
  typedef struct packed {
    logic [ANG_W-1:0]  pan_min;
    logic [ANG_W-1:0]  pan_max;
    logic [ANG_W-1:0]  tilt_min;
    logic [ANG_W-1:0]  tilt_max;
    logic [STEP_W-1:0] slew_step;
    logic [STEP_W-1:0] move_step;
    logic [ANG_W-1:0]  home_pan;
    logic [ANG_W-1:0]  home_tilt;
  } cfg_t;

  // Classified tick handed from front to back
  typedef struct packed {
    cmd_t                       cmd;
    logic [ANG_W-1:0]           set_pan;
    logic [ANG_W-1:0]           set_tilt;
    logic signed [DELTA_W-1:0]  d_pan;
    logic signed [DELTA_W-1:0]  d_tilt;
  } op_t;

  // Result beat
  typedef struct packed {
    logic [ANG_W-1:0] pan_position;
    logic [ANG_W-1:0] tilt_position;
    logic [ANG_W-1:0] pan_goal;
    logic [ANG_W-1:0] tilt_goal;
  } res_t;

  // Coefficient table indexed by {a, b}: floor(a / sqrt(a^2 + b^2) * 2^COEF_FRAC)
  typedef logic [15:0][COEF_W-1:0] coef_tab_t;

  // Build the table by a bitwise root search: largest r with r^2 * s <= a^2 << 2F
  function automatic coef_tab_t build_coef();
    coef_tab_t        tab;
    logic [WIDE_W-1:0] lim;
    logic [WIDE_W-1:0] r;
    logic [WIDE_W-1:0] trial;
    logic [WIDE_W-1:0] s;
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        s   = WIDE_W'(a * a + b * b);
        lim = WIDE_W'(a * a) << (2 * COEF_FRAC);
        r   = '0;
        if (a != 0) begin
          for (int k = COEF_W - 1; k >= 0; k--) begin
            trial = r | (WIDE_W'(1) << k);
            if (trial * trial * s <= lim) begin
              r = trial;
            end
          end
        end
        tab[a * 4 + b] = COEF_W'(r);
      end
    end
    return tab;
  endfunction

  localparam coef_tab_t UNIT_COEF = build_coef();

endpackage

[src/pan_tilt_slew_controller_unit.sv]
// ----------------------------------------------------------------------------
// pan_tilt_slew_controller_unit: two-axis slew-rate limiter for a pan/tilt head
// Throughput: one tick per cycle while the result queue has room; the back
//   part's state loop (command, add, clamp, slew) finishes a tick each cycle.
// Path: a tick is registered in the command queue, updated combinationally by
//   the back part, then registered in the result queue.
// Reset: synchronous; queues empty, registers at their defaults, all
//   positions, targets and saved positions at 90 degrees.
// ----------------------------------------------------------------------------
module pan_tilt_slew_controller_unit import ptsc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [FUNC_W-1:0] func,
  input  logic [KEY_W-1:0]  key_mask,
  input  logic [ANG_W-1:0]  set_pan,
  input  logic [ANG_W-1:0]  set_tilt,
  output logic              empty,
  input  logic              pop,
  output logic [ANG_W-1:0]  pan_position,
  output logic [ANG_W-1:0]  tilt_position,
  output logic [ANG_W-1:0]  pan_goal,
  output logic [ANG_W-1:0]  tilt_goal,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_index,
  input  logic [DATA_W-1:0] wr_data
);

  localparam logic [ANG_W-1:0]  RST_PAN_MIN  = ANG_W'(32'(70) << FRAC_BITS);
  localparam logic [ANG_W-1:0]  RST_PAN_MAX  = ANG_W'(32'(170) << FRAC_BITS);
  localparam logic [ANG_W-1:0]  RST_TILT_MAX = ANG_W'(32'(180) << FRAC_BITS);
  localparam logic [STEP_W-1:0] RST_STEP     = STEP_W'(32'(1) << FRAC_BITS);
  localparam logic [ANG_W-1:0]  RST_HOME     = ANG_W'(32'(90) << FRAC_BITS);

  cfg_t cfg;
  op_t  front_op, back_op;
  logic op_empty, op_take;
  res_t back_res, out_res;
  logic res_full, res_push;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pan_min   <= RST_PAN_MIN;
      cfg.pan_max   <= RST_PAN_MAX;
      cfg.tilt_min  <= '0;
      cfg.tilt_max  <= RST_TILT_MAX;
      cfg.slew_step <= RST_STEP;
      cfg.move_step <= RST_STEP;
      cfg.home_pan  <= RST_HOME;
      cfg.home_tilt <= RST_HOME;
    end else if (wr_en) begin
      case (wr_index)
        REG_PAN_MIN:   cfg.pan_min   <= wr_data[ANG_W-1:0];
        REG_PAN_MAX:   cfg.pan_max   <= wr_data[ANG_W-1:0];
        REG_TILT_MIN:  cfg.tilt_min  <= wr_data[ANG_W-1:0];
        REG_TILT_MAX:  cfg.tilt_max  <= wr_data[ANG_W-1:0];
        REG_SLEW_STEP: cfg.slew_step <= wr_data[STEP_W-1:0];
        REG_MOVE_STEP: cfg.move_step <= wr_data[STEP_W-1:0];
        REG_HOME_PAN:  cfg.home_pan  <= wr_data[ANG_W-1:0];
        REG_HOME_TILT: cfg.home_tilt <= wr_data[ANG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Classify ticks and work out key motion
  ptsc_front u_front (
    .func      (func),
    .key_mask  (key_mask),
    .set_pan   (set_pan),
    .set_tilt  (set_tilt),
    .move_step (cfg.move_step),
    .op        (front_op)
  );

  // Queue classified ticks between the two parts
  ptsc_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_op),
    .full  (full),
    .pop   (op_take),
    .dout  (back_op),
    .empty (op_empty)
  );

  // Update targets and positions
  ptsc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op       (back_op),
    .op_valid (!op_empty),
    .op_take  (op_take),
    .res_full (res_full),
    .res      (back_res),
    .res_push (res_push)
  );

  // Hold results until taken
  ptsc_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (back_res),
    .full  (res_full),
    .pop   (pop),
    .dout  (out_res),
    .empty (empty)
  );

  assign pan_position  = out_res.pan_position;
  assign tilt_position = out_res.tilt_position;
  assign pan_goal      = out_res.pan_goal;
  assign tilt_goal     = out_res.tilt_goal;

endmodule

[src/ptsc_fifo.sv]
// ----------------------------------------------------------------------------
// ptsc_fifo: small synchronous queue
// Register-based queue with push/full and pop/empty sides; the oldest entry
// is shown on dout while empty is low.
// ----------------------------------------------------------------------------
module ptsc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Advance pointers and count
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (do_pop && !do_push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

[src/ptsc_front.sv]
// ----------------------------------------------------------------------------
// ptsc_front: tick classification and key motion
// Maps the command code, sums the direction keys into a vector and scales
// its unit vector by move_step, rounding each axis to the nearest LSB.
// ----------------------------------------------------------------------------
module ptsc_front import ptsc_pkg::*; (
  input  logic [FUNC_W-1:0] func,
  input  logic [KEY_W-1:0]  key_mask,
  input  logic [ANG_W-1:0]  set_pan,
  input  logic [ANG_W-1:0]  set_tilt,
  input  logic [STEP_W-1:0] move_step,
  output op_t               op
);

  localparam int PROD_W = STEP_W + COEF_W;

  logic [1:0]              px, nx, py, ny;
  logic [1:0]              ax, ay;
  logic                    dx_pos, dy_neg;
  logic [COEF_W-1:0]       coef_pan, coef_tilt;
  logic [PROD_W:0]         prod_pan, prod_tilt;
  logic [STEP_W-1:0]       mag_pan, mag_tilt;
  cmd_t                    cmd;

  // Classify the command; unused codes act as no command
  always_comb begin
    case (func)
      CMD_HOME:    cmd = CMD_HOME;
      CMD_SAVE:    cmd = CMD_SAVE;
      CMD_RESTORE: cmd = CMD_RESTORE;
      CMD_SET:     cmd = CMD_SET;
      default:     cmd = CMD_NONE;
    endcase
  end

  // Count keys pushing each way: Q W E A D Z X C
  assign px = {1'b0, key_mask[2]} + {1'b0, key_mask[4]} + {1'b0, key_mask[7]};
  assign nx = {1'b0, key_mask[0]} + {1'b0, key_mask[3]} + {1'b0, key_mask[5]};
  assign py = {1'b0, key_mask[0]} + {1'b0, key_mask[1]} + {1'b0, key_mask[2]};
  assign ny = {1'b0, key_mask[5]} + {1'b0, key_mask[6]} + {1'b0, key_mask[7]};

  assign dx_pos = (px > nx);
  assign dy_neg = (ny > py);
  assign ax     = (px >= nx) ? px - nx : nx - px;
  assign ay     = (py >= ny) ? py - ny : ny - py;

  // Look up the unit-vector components
  assign coef_pan  = UNIT_COEF[{ay, ax}];
  assign coef_tilt = UNIT_COEF[{ax, ay}];

  // Scale and round to nearest
  assign prod_pan  = (PROD_W + 1)'(move_step) * (PROD_W + 1)'(coef_pan)
                   + ((PROD_W + 1)'(1) << (COEF_FRAC - 1));
  assign prod_tilt = (PROD_W + 1)'(move_step) * (PROD_W + 1)'(coef_tilt)
                   + ((PROD_W + 1)'(1) << (COEF_FRAC - 1));
  assign mag_pan   = prod_pan[COEF_FRAC +: STEP_W];
  assign mag_tilt  = prod_tilt[COEF_FRAC +: STEP_W];

  // Pan follows dy, tilt follows -dx
  always_comb begin
    op.cmd      = cmd;
    op.set_pan  = set_pan;
    op.set_tilt = set_tilt;
    op.d_pan    = dy_neg ? -$signed({1'b0, mag_pan}) : $signed({1'b0, mag_pan});
    op.d_tilt   = dx_pos ? -$signed({1'b0, mag_tilt}) : $signed({1'b0, mag_tilt});
  end

endmodule

[src/ptsc_back.sv]
// ----------------------------------------------------------------------------
// ptsc_back: target and position update
// Applies the command, adds the key motion to the targets, clamps them to
// the limits and slews each position toward its target.
// ----------------------------------------------------------------------------
module ptsc_back import ptsc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  op_t  op,
  input  logic op_valid,
  output logic op_take,
  input  logic res_full,
  output res_t res,
  output logic res_push
);

  localparam int SUM_W = ANG_W + 2;
  localparam logic [ANG_W-1:0] RST_ANGLE = ANG_W'(32'(90) << FRAC_BITS);

  logic [ANG_W-1:0] pan_now, pan_now_next;
  logic [ANG_W-1:0] tilt_now, tilt_now_next;
  logic [ANG_W-1:0] pan_aim, pan_aim_next;
  logic [ANG_W-1:0] tilt_aim, tilt_aim_next;
  logic [ANG_W-1:0] pan_kept, pan_kept_next;
  logic [ANG_W-1:0] tilt_kept, tilt_kept_next;
  logic [ANG_W-1:0] pan_base, tilt_base;
  logic signed [SUM_W-1:0] pan_sum, tilt_sum;
  logic             fire;

  // Clamp: test the low limit first, then the high one
  function automatic logic [ANG_W-1:0] clamp_lim(logic signed [SUM_W-1:0] v,
                                                 logic [ANG_W-1:0] lo,
                                                 logic [ANG_W-1:0] hi);
    logic signed [SUM_W-1:0] t;
    t = v;
    if (t < $signed({2'b00, lo})) begin
      t = $signed({2'b00, lo});
    end
    if (t > $signed({2'b00, hi})) begin
      t = $signed({2'b00, hi});
    end
    return t[ANG_W-1:0];
  endfunction

  // Move toward the target by at most one step
  function automatic logic [ANG_W-1:0] slew(logic [ANG_W-1:0] now,
                                            logic [ANG_W-1:0] aim,
                                            logic [STEP_W-1:0] step);
    logic signed [ANG_W:0] diff;
    logic signed [ANG_W:0] mag;
    logic [ANG_W-1:0]      r;
    diff = $signed({1'b0, aim}) - $signed({1'b0, now});
    mag  = (diff < 0) ? -diff : diff;
    if (mag <= $signed({{(ANG_W + 1 - STEP_W){1'b0}}, step})) begin
      r = aim;
    end else if (diff > 0) begin
      r = now + ANG_W'(step);
    end else begin
      r = now - ANG_W'(step);
    end
    return r;
  endfunction

  assign fire     = op_valid && !res_full;
  assign op_take  = fire;
  assign res_push = fire;

  // Apply the command
  always_comb begin
    pan_base       = pan_aim;
    tilt_base      = tilt_aim;
    pan_kept_next  = pan_kept;
    tilt_kept_next = tilt_kept;
    case (op.cmd)
      CMD_HOME: begin
        pan_base  = cfg.home_pan;
        tilt_base = cfg.home_tilt;
      end
      CMD_SAVE: begin
        pan_kept_next  = pan_now;
        tilt_kept_next = tilt_now;
      end
      CMD_RESTORE: begin
        pan_base  = pan_kept;
        tilt_base = tilt_kept;
      end
      CMD_SET: begin
        pan_base  = clamp_lim($signed({2'b00, op.set_pan}), cfg.pan_min, cfg.pan_max);
        tilt_base = clamp_lim($signed({2'b00, op.set_tilt}), cfg.tilt_min, cfg.tilt_max);
      end
      default: begin
      end
    endcase
  end

  // Add key motion, clamp, then slew
  always_comb begin
    pan_sum  = $signed({2'b00, pan_base})
             + $signed({{(SUM_W - DELTA_W){op.d_pan[DELTA_W-1]}}, op.d_pan});
    tilt_sum = $signed({2'b00, tilt_base})
             + $signed({{(SUM_W - DELTA_W){op.d_tilt[DELTA_W-1]}}, op.d_tilt});
    pan_aim_next  = clamp_lim(pan_sum, cfg.pan_min, cfg.pan_max);
    tilt_aim_next = clamp_lim(tilt_sum, cfg.tilt_min, cfg.tilt_max);
    pan_now_next  = slew(pan_now, pan_aim_next, cfg.slew_step);
    tilt_now_next = slew(tilt_now, tilt_aim_next, cfg.slew_step);
  end

  always_comb begin
    res.pan_position  = pan_now_next;
    res.tilt_position = tilt_now_next;
    res.pan_goal      = pan_aim_next;
    res.tilt_goal     = tilt_aim_next;
  end

  // Hold state between ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      pan_now   <= RST_ANGLE;
      tilt_now  <= RST_ANGLE;
      pan_aim   <= RST_ANGLE;
      tilt_aim  <= RST_ANGLE;
      pan_kept  <= RST_ANGLE;
      tilt_kept <= RST_ANGLE;
    end else if (fire) begin
      pan_now   <= pan_now_next;
      tilt_now  <= tilt_now_next;
      pan_aim   <= pan_aim_next;
      tilt_aim  <= tilt_aim_next;
      pan_kept  <= pan_kept_next;
      tilt_kept <= tilt_kept_next;
    end
  end

endmodule
